// ----- hdl/srmt_pkg.sv -----
// ----------------------------------------------------------------------------
// srmt_pkg: shared types for the sorted region map table
// Entry layout, channel payloads, status and command codes, sequencer states.
// ----------------------------------------------------------------------------
package srmt_pkg;

  localparam int MAX_REGIONS  = 64;
  localparam int IDX_W        = $clog2(MAX_REGIONS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = 47;
  localparam int AREA_W       = 8;
  localparam int PERM_W       = 3;
  localparam int PAGE_BYTES   = 4096;

  localparam logic [ADDR_W-1:0] PAGE = ADDR_W'(PAGE_BYTES);
  // user space size minus one page
  localparam logic [ADDR_W-1:0] EMPTY_LIMIT = ADDR_W'(0) - PAGE;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_FAULT  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNMAPPED = 3'd1,
    ST_DISABLED = 3'd2,
    ST_NO_PERM  = 3'd3,
    ST_OUTSIDE  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  localparam logic [PERM_W-1:0] PERM_NONE = 3'd0;
  localparam logic [PERM_W-1:0] PERM_RW   = 3'd2;
  localparam logic [PERM_W-1:0] PERM_RWX  = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [AREA_W-1:0] area_id;
    logic [ADDR_W-1:0] area_offset;
    logic [PERM_W-1:0] permissions;
    logic              need_write;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              hit;
    logic [6:0]        entry_index;
    logic [ADDR_W-1:0] placed_start;
    logic [AREA_W-1:0] hit_area_id;
    logic [ADDR_W-1:0] area_position;
    logic [ADDR_W-1:0] remaining_length;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic [AREA_W-1:0] area;
    logic [ADDR_W-1:0] offset;
    logic [PERM_W-1:0] perm;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_OVL_RD,
    S_OVL_CMP,
    S_GAP_START,
    S_GAP_RD,
    S_GAP_CMP,
    S_SH_CHK,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_FIN
  } state_t;

endpackage

// ----- hdl/srmt_chan_if.sv -----
// ----------------------------------------------------------------------------
// srmt_chan_if: valid/ready channel
// One transfer when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface srmt_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/sorted_region_map_table.sv -----
// ----------------------------------------------------------------------------
// sorted_region_map_table: sorted address region table with binary search
//
//   channel  dir  payload  transfer
//   req      in   req_t    req.valid && req.ready
//   rsp      out  rsp_t    rsp.valid && rsp.ready
//
// One command at a time; a table memory with separate read and write ports and
// registered read data sets the pace. Search is a binary search, a read and a
// compare per probe. Insert adds an overlap probe, a gap scan and a shift per
// moved entry; remove adds a shift per moved entry. rst clears the entry count,
// the sequencer and the output valid only.
// The result waits in an output register; a new command is taken meanwhile.
// ----------------------------------------------------------------------------
module sorted_region_map_table
  import srmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  srmt_chan_if.sink   req,
  srmt_chan_if.source rsp
);

  entry_t mem [MAX_REGIONS];
  entry_t rdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic   we;
  entry_t wdata;

  state_t state, state_next;

  req_t             r;
  logic [CNT_W-1:0] count, lo, hi, rd_idx, idx, gi, ptr;
  logic             final_f, hit_f;
  entry_t           ent;
  logic [ADDR_W:0]  prev_end;
  logic [ADDR_W-1:0] st;
  logic [2:0]       status_r;
  rsp_t             out_r;
  rsp_t             out_next;
  logic             out_valid;

  logic             in_fire, ins;
  logic             ovf, s_inside, s_below, resolved, ovl, g0_fit, gn_fit, empty_fit;
  logic [CNT_W-1:0] mid, srch_idx;
  logic [ADDR_W:0]  sum_al, rd_end;
  logic [ADDR_W+1:0] gdiff;
  logic             fin_take;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign ins       = (r.cmd == CMD_INSERT);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_r;
  assign fin_take  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // region end checks on incoming insert
  assign sum_al = {1'b0, req.data.address} + {1'b0, req.data.length};
  assign ovf    = (req.data.length != '0) && ((sum_al - 1'b1) > {1'b0, {ADDR_W{1'b1}}});

  assign mid      = lo + ((hi - lo) >> 1);
  assign rd_end   = {1'b0, rdata.start} + {1'b0, rdata.length};
  assign s_below  = r.address < rdata.start;
  assign s_inside = !s_below && ((r.address - rdata.start) < rdata.length);
  assign resolved = s_inside || final_f || (s_below && rd_idx == lo);
  assign srch_idx = s_inside ? rd_idx :
                    final_f  ? (s_below ? lo : lo + 1'b1) : rd_idx;

  assign ovl = ({1'b0, r.address} < rd_end) &&
               ({1'b0, rdata.start} < ({1'b0, r.address} + {1'b0, r.length}));
  assign empty_fit = r.length < EMPTY_LIMIT;
  assign g0_fit = (rdata.start > PAGE) && (r.length < rdata.start - PAGE);
  assign gdiff  = {2'b0, rdata.start} - {1'b0, prev_end};
  assign gn_fit = gdiff[ADDR_W+1] || (gdiff[ADDR_W:0] >= {1'b0, r.length});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) begin
        if (req.data.cmd == CMD_INSERT && (ovf || count >= CNT_W'(MAX_REGIONS)))
          state_next = S_FIN;
        else if (count == '0)
          state_next = S_DECIDE;
        else
          state_next = S_SRCH_RD;
      end
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: state_next = resolved ? S_DECIDE : S_SRCH_RD;
      S_DECIDE: begin
        unique case (r.cmd)
          CMD_INSERT:
            if (r.address == '0 || hit_f) state_next = S_GAP_START;
            else if (idx < count)         state_next = S_OVL_RD;
            else                          state_next = S_SH_CHK;
          CMD_REMOVE:
            state_next = (hit_f && ent.start == r.address) ? S_SH_CHK : S_FIN;
          default: state_next = S_FIN;
        endcase
      end
      S_OVL_RD:  state_next = S_OVL_CMP;
      S_OVL_CMP: state_next = ovl ? S_GAP_START : S_SH_CHK;
      S_GAP_START:
        if (count == '0) state_next = empty_fit ? S_SH_CHK : S_FIN;
        else             state_next = S_GAP_RD;
      S_GAP_RD: state_next = S_GAP_CMP;
      S_GAP_CMP: begin
        if ((gi == '0) ? g0_fit : gn_fit) state_next = S_SH_CHK;
        else if (gi + 1'b1 >= count)      state_next = S_FIN;
        else                              state_next = S_GAP_RD;
      end
      S_SH_CHK:
        if (ins) state_next = (ptr > idx) ? S_SH_RD : S_PUT;
        else     state_next = (ptr + 1'b1 < count) ? S_SH_RD : S_PUT;
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: state_next = S_SH_CHK;
      S_PUT:   state_next = S_FIN;
      S_FIN:   state_next = fin_take ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = ptr[IDX_W-1:0];
    wdata = rdata;
    unique case (state)
      S_SRCH_RD: raddr = (lo < hi) ? mid[IDX_W-1:0] : lo[IDX_W-1:0];
      S_OVL_RD:  raddr = idx[IDX_W-1:0];
      S_GAP_RD:  raddr = gi[IDX_W-1:0];
      S_SH_RD:   raddr = ins ? IDX_W'(ptr - 1'b1) : IDX_W'(ptr + 1'b1);
      S_SH_WR:   we = 1'b1;
      S_PUT: begin
        we    = ins;
        waddr = idx[IDX_W-1:0];
        wdata = '{start: st, length: r.length, area: r.area_id,
                  offset: r.area_offset, perm: r.permissions};
      end
      default: ;
    endcase
  end

  // result of the current command
  always_comb begin
    out_next = '0;
    out_next.hit = hit_f;
    out_next.entry_index = 7'(idx);
    unique case (r.cmd)
      CMD_INSERT: begin
        out_next.status = status_r;
        if (status_r != ST_OK) out_next.entry_index = '0;
        else                   out_next.placed_start = st;
      end
      CMD_REMOVE: out_next.status = status_r;
      CMD_LOOKUP:
        if (!hit_f) out_next.status = ST_UNMAPPED;
        else if (r.need_write && ent.perm != PERM_RW && ent.perm != PERM_RWX)
          out_next.status = ST_NO_PERM;
        else begin
          out_next.hit_area_id      = ent.area;
          out_next.area_position    = r.address - ent.start + ent.offset;
          out_next.remaining_length = ent.start + ent.length - r.address;
        end
      default:
        if (!hit_f)                        out_next.status = ST_UNMAPPED;
        else if (ent.perm == PERM_NONE)    out_next.status = ST_DISABLED;
        else if (r.permissions > ent.perm) out_next.status = ST_NO_PERM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire) begin
          r        <= req.data;
          hit_f    <= 1'b0;
          idx      <= '0;
          lo       <= '0;
          hi       <= count - 1'b1;
          status_r <= (req.data.cmd == CMD_INSERT && ovf) ? ST_OUTSIDE :
                      (req.data.cmd == CMD_INSERT &&
                       count >= CNT_W'(MAX_REGIONS))      ? ST_FULL : ST_OK;
        end
        S_SRCH_RD: begin
          final_f <= !(lo < hi);
          rd_idx  <= (lo < hi) ? mid : lo;
        end
        S_SRCH_CMP: begin
          ent <= rdata;
          if (resolved) begin
            hit_f <= s_inside;
            idx   <= srch_idx;
          end else if (s_below) hi <= rd_idx - 1'b1;
          else                  lo <= rd_idx + 1'b1;
        end
        S_DECIDE: begin
          st  <= r.address;
          ptr <= ins ? count : idx;
          if (r.cmd == CMD_REMOVE && !(hit_f && ent.start == r.address))
            status_r <= ST_UNMAPPED;
        end
        S_GAP_START: begin
          gi  <= '0;
          st  <= PAGE;
          idx <= '0;
          if (count == '0 && !empty_fit) status_r <= ST_FULL;
        end
        S_GAP_CMP: begin
          if ((gi == '0) ? g0_fit : gn_fit) begin
            if (gi != '0) st <= prev_end[ADDR_W-1:0];
            idx <= gi;
          end else begin
            prev_end <= rd_end;
            gi       <= gi + 1'b1;
            if (gi + 1'b1 >= count) status_r <= ST_FULL;
          end
        end
        S_SH_WR: ptr <= ins ? ptr - 1'b1 : ptr + 1'b1;
        S_PUT:   count <= ins ? count + 1'b1 : count - 1'b1;
        S_FIN: if (fin_take) begin
          out_valid <= 1'b1;
          out_r     <= out_next;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted region map table
// Commands go in through a driver fed from a queue, results are checked by a
// monitor. Each check uses a copy of the region table that is kept in the
// bench. Both channels idle at random, and the bench also applies a long
// output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import srmt_pkg::*;

  typedef logic [63:0] u64;

  localparam logic [PERM_W-1:0] PERM_READ = 3'd1;
  localparam logic [PERM_W-1:0] PERM_RX   = 3'd3;
  localparam u64 USER_TOP = (u64'(1) << ADDR_W) - 1;
  localparam u64 PG = u64'(PAGE_BYTES);

  logic clk;
  logic rst;

  srmt_chan_if #(.T(req_t)) req_ch ();
  srmt_chan_if #(.T(rsp_t)) rsp_ch ();

  sorted_region_map_table DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // copy of the region table
  u64 tbl_start  [MAX_REGIONS];
  u64 tbl_len    [MAX_REGIONS];
  u64 tbl_area   [MAX_REGIONS];
  u64 tbl_offset [MAX_REGIONS];
  u64 tbl_perm   [MAX_REGIONS];
  int tbl_count;

  req_t pending_q [$];
  rsp_t expected_q [$];

  int  errors;
  int  accepted;
  int  results;
  int  cmd_seen [4];
  int  ok_seen;
  int  hit_seen;
  int  full_seen;
  bit  req_taken;
  bit  quiet;
  bit  rsp_hold;
  bit  req_pause;
  bit  stim_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit in_region(int i, u64 a);
    return a >= tbl_start[i] && a - tbl_start[i] < tbl_len[i];
  endfunction

  function automatic u64 region_end(int i);
    return tbl_start[i] + tbl_len[i];
  endfunction

  // binary search: containing index, or insertion position on a miss
  function automatic int search_table(u64 a, output bit hit);
    int lo, hi, mid;
    hit = 1'b0;
    if (tbl_count == 0) return 0;
    lo = 0;
    hi = tbl_count - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (in_region(mid, a)) begin
        hit = 1'b1;
        return mid;
      end
      if (a < tbl_start[mid]) begin
        if (mid == lo) return mid;
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    if (in_region(lo, a)) begin
      hit = 1'b1;
      return lo;
    end
    return (a < tbl_start[lo]) ? lo : lo + 1;
  endfunction

  // first fit; the space above the last region is never used
  function automatic bit first_fit(u64 len, output u64 st, output int pos);
    st = 0;
    pos = 0;
    if (tbl_count == 0) begin
      st = PG;
      return len < USER_TOP - PG + 1;
    end
    if (tbl_start[0] > PG && len < tbl_start[0] - PG) begin
      st = PG;
      return 1'b1;
    end
    for (int i = 1; i < tbl_count; i++) begin
      if (tbl_start[i] - region_end(i - 1) >= len) begin
        st = region_end(i - 1);
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    u64 a, len, st;
    bit hit, fits;
    int idx;
    o = '0;
    a = u64'(r.address);
    len = u64'(r.length);
    if (cmd_t'(r.cmd) == CMD_INSERT) begin
      if (a > USER_TOP || (len != 0 && len - 1 > USER_TOP - a)) begin
        o.status = ST_OUTSIDE;
      end else if (tbl_count >= MAX_REGIONS) begin
        o.status = ST_FULL;
      end else begin
        st = a;
        fits = 1'b1;
        idx = search_table(a, hit);
        o.hit = hit;
        if (a == 0 || hit ||
            (idx < tbl_count && a < region_end(idx) && tbl_start[idx] < a + len))
          fits = first_fit(len, st, idx);
        if (!fits) begin
          o.status = ST_FULL;
        end else begin
          for (int i = tbl_count; i > idx; i--) begin
            tbl_start[i]  = tbl_start[i-1];
            tbl_len[i]    = tbl_len[i-1];
            tbl_area[i]   = tbl_area[i-1];
            tbl_offset[i] = tbl_offset[i-1];
            tbl_perm[i]   = tbl_perm[i-1];
          end
          tbl_start[idx]  = st;
          tbl_len[idx]    = len;
          tbl_area[idx]   = u64'(r.area_id);
          tbl_offset[idx] = u64'(r.area_offset);
          tbl_perm[idx]   = u64'(r.permissions);
          tbl_count++;
          o.entry_index = 7'(idx);
          o.placed_start = st[ADDR_W-1:0];
        end
      end
    end else if (a > USER_TOP) begin
      o.status = ST_OUTSIDE;
    end else begin
      idx = search_table(a, hit);
      o.hit = hit;
      o.entry_index = 7'(idx);
      if (cmd_t'(r.cmd) == CMD_REMOVE) begin
        if (!hit || tbl_start[idx] != a) begin
          o.status = ST_UNMAPPED;
        end else begin
          for (int i = idx; i + 1 < tbl_count; i++) begin
            tbl_start[i]  = tbl_start[i+1];
            tbl_len[i]    = tbl_len[i+1];
            tbl_area[i]   = tbl_area[i+1];
            tbl_offset[i] = tbl_offset[i+1];
            tbl_perm[i]   = tbl_perm[i+1];
          end
          tbl_count--;
        end
      end else if (!hit) begin
        o.status = ST_UNMAPPED;
      end else if (cmd_t'(r.cmd) == CMD_LOOKUP) begin
        if (r.need_write && tbl_perm[idx] != u64'(PERM_RW) &&
            tbl_perm[idx] != u64'(PERM_RWX)) begin
          o.status = ST_NO_PERM;
        end else begin
          o.hit_area_id = tbl_area[idx][AREA_W-1:0];
          o.area_position = ADDR_W'(a - tbl_start[idx] + tbl_offset[idx]);
          o.remaining_length = ADDR_W'(region_end(idx) - a);
        end
      end else begin
        if (tbl_perm[idx] == u64'(PERM_NONE)) o.status = ST_DISABLED;
        else if (u64'(r.permissions) > tbl_perm[idx]) o.status = ST_NO_PERM;
      end
    end
    return o;
  endfunction

  function automatic req_t mk_req(cmd_t c, u64 a, u64 len, logic [PERM_W-1:0] p,
                                  bit nw);
    req_t r;
    r.cmd = c;
    r.address = a[ADDR_W-1:0];
    r.length = len[ADDR_W-1:0];
    r.area_id = AREA_W'($urandom);
    r.area_offset = ADDR_W'({$urandom, $urandom});
    r.permissions = p;
    r.need_write = nw;
    return r;
  endfunction

  // mostly page-aligned traffic in a small window so that hits, relocations
  // and a full table all happen; one item in ten is unconstrained noise
  function automatic req_t random_req();
    req_t r;
    u64 a;
    int pick;
    pick = $urandom_range(0, 99);
    a = PG * $urandom_range(0, 90);
    if ($urandom_range(0, 9) == 0) a += $urandom_range(1, PAGE_BYTES - 1);
    if (pick < 10) begin
      r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (pick < 50) begin
      r = mk_req(CMD_INSERT, a, PG * $urandom_range(1, 4),
                 PERM_W'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 19) == 0) r.length = ADDR_W'($urandom_range(0, 9000));
    end else if (pick < 72) begin
      r = mk_req(CMD_REMOVE, a, 0, PERM_W'($urandom), 1'($urandom_range(0, 1)));
    end else if (pick < 88) begin
      r = mk_req(CMD_LOOKUP, a, 0, PERM_W'($urandom), 1'($urandom_range(0, 1)));
    end else begin
      r = mk_req(CMD_FAULT, a, 0, PERM_W'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)));
    end
    return r;
  endfunction

  task automatic check_field(string name, u64 exp_v, u64 act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    rsp_t e, g;
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_q.push_back(apply_command(req_ch.data));
      cmd_seen[req_ch.data.cmd]++;
      accepted++;
      req_taken = 1'b1;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      g = rsp_ch.data;
      results++;
      if (expected_q.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.status == ST_OK) ok_seen++;
        if (e.status == ST_FULL) full_seen++;
        if (e.hit) hit_seen++;
        check_field("status", u64'(e.status), u64'(g.status));
        check_field("hit", u64'(e.hit), u64'(g.hit));
        check_field("entry_index", u64'(e.entry_index), u64'(g.entry_index));
        check_field("placed_start", u64'(e.placed_start), u64'(g.placed_start));
        check_field("hit_area_id", u64'(e.hit_area_id), u64'(g.hit_area_id));
        check_field("area_position", u64'(e.area_position), u64'(g.area_position));
        check_field("remaining_length", u64'(e.remaining_length),
                    u64'(g.remaining_length));
      end
    end
  end

  // drive at the falling edge
  always @(negedge clk) begin
    bit nv;
    req_t nd;
    nv = req_ch.valid;
    nd = req_ch.data;
    if (rst) begin
      nv = 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      nv = 1'b0;
      if (pending_q.size() != 0 && !req_pause &&
          (quiet || $urandom_range(0, 99) >= 25)) begin
        nd = pending_q.pop_front();
        nv = 1'b1;
      end
    end
    req_taken = 1'b0;
    req_ch.valid <= nv;
    req_ch.data <= nd;
    rsp_ch.ready <= !rst && !rsp_hold && (quiet || $urandom_range(0, 99) >= 25);
  end

  // output held off for a long stretch mid-run
  initial begin
    rsp_hold = 1'b0;
    wait (accepted >= 300);
    @(negedge clk);
    rsp_hold = 1'b1;
    repeat (400) @(negedge clk);
    rsp_hold = 1'b0;
  end

  // no idling for a stretch, then a drain pause on the input side
  initial begin
    quiet = 1'b0;
    req_pause = 1'b0;
    wait (accepted >= 500);
    quiet = 1'b1;
    wait (accepted >= 750);
    quiet = 1'b0;
    wait (accepted >= 900);
    req_pause = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    req_pause = 1'b0;
  end

  initial begin
    errors = 0;
    accepted = 0;
    results = 0;
    ok_seen = 0;
    hit_seen = 0;
    full_seen = 0;
    cmd_seen = '{default: 0};
    tbl_count = 0;
    req_taken = 1'b0;
    stim_done = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;

    // directed: empty table, extremes, relocation, permissions, removes
    pending_q.push_back(mk_req(CMD_LOOKUP, PG, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_FAULT, 0, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_REMOVE, PG, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_INSERT, 0, USER_TOP + 1 - PG, PERM_RW, 0));
    pending_q.push_back(mk_req(CMD_INSERT, USER_TOP, 2 * PG, PERM_RW, 0));
    pending_q.push_back(mk_req(CMD_INSERT, 0, PG, PERM_READ, 1));
    pending_q.push_back(mk_req(CMD_INSERT, 10 * PG, 2 * PG, PERM_RW, 0));
    pending_q.push_back(mk_req(CMD_INSERT, 10 * PG, PG, PERM_RWX, 0));
    pending_q.push_back(mk_req(CMD_INSERT, 9 * PG, 2 * PG, PERM_NONE, 0));
    pending_q.push_back(mk_req(CMD_INSERT, 20 * PG + 5, 0, 3'd7, 0));
    pending_q.push_back(mk_req(CMD_INSERT, 30 * PG, 100, PERM_RX, 1));
    pending_q.push_back(mk_req(CMD_INSERT, USER_TOP + 1 - PG, PG, PERM_RWX, 0));
    pending_q.push_back(mk_req(CMD_LOOKUP, 10 * PG + 17, 0, PERM_READ, 1));
    pending_q.push_back(mk_req(CMD_LOOKUP, PG + 3, 0, PERM_READ, 1));
    pending_q.push_back(mk_req(CMD_LOOKUP, 30 * PG + 99, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_LOOKUP, USER_TOP, 0, PERM_READ, 1));
    pending_q.push_back(mk_req(CMD_FAULT, 11 * PG, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_FAULT, 10 * PG, 0, PERM_RWX, 0));
    pending_q.push_back(mk_req(CMD_FAULT, 30 * PG, 0, 3'd7, 0));
    pending_q.push_back(mk_req(CMD_FAULT, 12 * PG, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_REMOVE, 10 * PG + 8, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_REMOVE, 10 * PG, 0, PERM_READ, 0));
    pending_q.push_back(mk_req(CMD_REMOVE, USER_TOP + 1 - PG, 0, PERM_READ, 0));
    for (int i = 0; i < 1530; i++) pending_q.push_back(random_req());

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    stim_done = 1'b1;
    $display("commands: %0d insert, %0d remove, %0d lookup, %0d fault; results %0d",
             cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE], cmd_seen[CMD_LOOKUP],
             cmd_seen[CMD_FAULT], results);
    $display("outcomes: %0d ok, %0d hits, %0d full or no gap, %0d mismatches",
             ok_seen, hit_seen, full_seen, errors);
    if (errors == 0 && expected_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("simulation failed");
    $finish;
  end

endmodule
